FILE: src/mpce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpce_pkg
// Shared types, the CRC preset catalogue and the one-byte CRC update used by
// the multi-preset CRC engine.
// ----------------------------------------------------------------------------
package mpce_pkg;

  localparam int unsigned CrcW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModeW    = 5;
  localparam int unsigned WidthW   = 6;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  // Register index of the preset select register.
  localparam logic [PaddrW-3:0] RegCrcMode = 1'b0;

  typedef enum logic [ModeW-1:0] {
    MODE_4_ITU, MODE_5_EPC, MODE_5_ITU, MODE_5_USB, MODE_6_ITU, MODE_7_MMC,
    MODE_8, MODE_8_ITU, MODE_8_ROHC, MODE_8_MAXIM, MODE_16_IBM, MODE_16_MAXIM,
    MODE_16_USB, MODE_16_MODBUS, MODE_16_CCITT, MODE_16_CCITT_FALSE, MODE_16_X25,
    MODE_16_XMODEM, MODE_16_DNP, MODE_32, MODE_32_MPEG2, MODE_FIRST_UNKNOWN,
    MODE_LAST_UNKNOWN = 5'd31
  } crc_mode_t;

  typedef struct packed {
    logic              known;
    logic [WidthW-1:0] width;
    logic [CrcW-1:0]   poly;
    logic [CrcW-1:0]   init;
    logic [CrcW-1:0]   xorout;
    logic              refl;
  } preset_t;

  function automatic preset_t preset_lookup(input logic [ModeW-1:0] mode);
    preset_t p;
    p = '{known: 1'b1, width: 6'd4, poly: 32'h0, init: 32'h0, xorout: 32'h0,
          refl: 1'b1};
    case (mode)
      MODE_4_ITU:   p = '{1'b1, 6'd4,  32'h0000000C, 32'h00000000, 32'h00000000, 1'b1};
      MODE_5_EPC:   p = '{1'b1, 6'd5,  32'h00000009, 32'h00000009, 32'h00000000, 1'b0};
      MODE_5_ITU:   p = '{1'b1, 6'd5,  32'h00000015, 32'h00000000, 32'h00000000, 1'b1};
      MODE_5_USB:   p = '{1'b1, 6'd5,  32'h00000014, 32'h0000001F, 32'h0000001F, 1'b1};
      MODE_6_ITU:   p = '{1'b1, 6'd6,  32'h00000030, 32'h00000000, 32'h00000000, 1'b1};
      MODE_7_MMC:   p = '{1'b1, 6'd7,  32'h00000009, 32'h00000000, 32'h00000000, 1'b0};
      MODE_8:       p = '{1'b1, 6'd8,  32'h00000007, 32'h00000000, 32'h00000000, 1'b0};
      MODE_8_ITU:   p = '{1'b1, 6'd8,  32'h00000007, 32'h00000000, 32'h00000055, 1'b0};
      MODE_8_ROHC:  p = '{1'b1, 6'd8,  32'h000000E0, 32'h000000FF, 32'h00000000, 1'b1};
      MODE_8_MAXIM: p = '{1'b1, 6'd8,  32'h0000008C, 32'h00000000, 32'h00000000, 1'b1};
      MODE_16_IBM:  p = '{1'b1, 6'd16, 32'h0000A001, 32'h00000000, 32'h00000000, 1'b1};
      MODE_16_MAXIM:
        p = '{1'b1, 6'd16, 32'h0000A001, 32'h00000000, 32'h0000FFFF, 1'b1};
      MODE_16_USB:  p = '{1'b1, 6'd16, 32'h0000A001, 32'h0000FFFF, 32'h0000FFFF, 1'b1};
      MODE_16_MODBUS:
        p = '{1'b1, 6'd16, 32'h0000A001, 32'h0000FFFF, 32'h00000000, 1'b1};
      MODE_16_CCITT:
        p = '{1'b1, 6'd16, 32'h00008408, 32'h00000000, 32'h00000000, 1'b1};
      MODE_16_CCITT_FALSE:
        p = '{1'b1, 6'd16, 32'h00001021, 32'h0000FFFF, 32'h00000000, 1'b0};
      MODE_16_X25:  p = '{1'b1, 6'd16, 32'h00008408, 32'h0000FFFF, 32'h0000FFFF, 1'b1};
      MODE_16_XMODEM:
        p = '{1'b1, 6'd16, 32'h00001021, 32'h00000000, 32'h00000000, 1'b0};
      MODE_16_DNP:  p = '{1'b1, 6'd16, 32'h0000A6BC, 32'h00000000, 32'h0000FFFF, 1'b1};
      MODE_32:      p = '{1'b1, 6'd32, 32'hEDB88320, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1};
      MODE_32_MPEG2:
        p = '{1'b1, 6'd32, 32'h04C11DB7, 32'hFFFFFFFF, 32'h00000000, 1'b0};
      default: p = '{1'b0, 6'd32, 32'h0, 32'h0, 32'h0, 1'b1};
    endcase
    return p;
  endfunction

  function automatic logic [CrcW-1:0] width_mask(input logic [WidthW-1:0] w);
    logic [CrcW:0] m;
    m = ({{CrcW{1'b0}}, 1'b1} << w) - {{CrcW{1'b0}}, 1'b1};
    return m[CrcW-1:0];
  endfunction

  // Narrow normal-form presets are worked left-aligned in the full word, which
  // gives the same result as the catalogue's 8-bit alignment.
  function automatic logic [CrcW-1:0] crc_absorb(input preset_t p,
                                                 input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0]   mask;
    logic [CrcW-1:0]   r;
    logic [CrcW-1:0]   lpoly;
    logic [WidthW-1:0] shl;
    mask  = width_mask(p.width);
    shl   = WidthW'(CrcW) - p.width;
    lpoly = p.poly << shl;
    if (p.refl) begin
      r = (crc & mask) ^ {{(CrcW-ByteW){1'b0}}, b};
      for (int i = 0; i < ByteW; i++) begin
        r = r[0] ? ((r >> 1) ^ p.poly) : (r >> 1);
      end
      return r & mask;
    end else begin
      r = ((crc & mask) << shl) ^ {b, {(CrcW-ByteW){1'b0}}};
      for (int i = 0; i < ByteW; i++) begin
        r = r[CrcW-1] ? ((r << 1) ^ lpoly) : (r << 1);
      end
      return r >> shl;
    end
  endfunction

endpackage

FILE: src/multi_preset_crc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_preset_crc_engine
// Bytewise CRC over a message stream with 21 selectable catalogue presets.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_stall  | in_data_byte, in_first_byte, in_last_byte
//   out     | out_valid/out_stall| out_crc_value
//   cfg     | APB write/read     | crc_mode at byte address 0
//
// One byte is taken per cycle while in_stall is low; the byte register feeds an
// unrolled 8-bit CRC update that writes the running CRC and the result register.
// The result register loads as the last byte leaves the byte register.
// Reset clears the running CRC, the preset select and both valid flags.
// A held result stalls the input only when another last byte is waiting.
// ----------------------------------------------------------------------------
module multi_preset_crc_engine
  import mpce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ByteW-1:0]  in_data_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CrcW-1:0]   out_crc_value,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [ModeW-1:0] mode_r;
  logic [CrcW-1:0]  crc_r;
  logic [CrcW-1:0]  crc_nxt;
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_data_r;
  logic             s1_first_r;
  logic             s1_last_r;
  logic             out_valid_r;
  logic [CrcW-1:0]  out_crc_r;
  logic [CrcW-1:0]  result_nxt;
  logic             advance;
  logic             in_xfer;
  logic             cfg_wr;
  preset_t          preset;
  logic [CrcW-1:0]  crc_start;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[PaddrW-1:2] == RegCrcMode);
  assign prdata = (paddr[PaddrW-1:2] == RegCrcMode) ?
                  {{(PdataW-ModeW){1'b0}}, mode_r} : '0;

  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    preset    = preset_lookup(mode_r);
    crc_start = s1_first_r ? preset.init : crc_r;
    if (preset.known) begin
      crc_nxt    = crc_absorb(preset, crc_start, s1_data_r);
      result_nxt = (crc_nxt ^ preset.xorout) & width_mask(preset.width);
    end else begin
      crc_nxt    = '0;
      result_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      crc_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mode_r <= pwdata[ModeW-1:0];
      end
      if (advance) begin
        crc_r <= crc_nxt;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_last_r  <= in_last_byte;
    end
    if (advance && s1_last_r) begin
      out_crc_r <= result_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule

FILE: src/mpce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpce_checker
// Port-level checks of the CRC engine's transfer behavior, bound to the top.
// ----------------------------------------------------------------------------
module mpce_checker
  import mpce_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            in_last_byte,
  input logic            out_valid,
  input logic            out_stall,
  input logic [CrcW-1:0] out_crc_value
);

  // A result that is not taken stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_crc_value))
    else $error("result changed while stalled");

  // Reset leaves no result pending and the input open.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("engine not idle after reset");

  // A fresh result follows an earlier last byte transfer.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_byte, 2))
    else $error("result without a matching last byte");

  // The input is only held back by a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind multi_preset_crc_engine mpce_checker u_mpce_checker (.*);

FILE: verif/multi_preset_crc_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_preset_crc_engine_tb
// Self-checking testbench for the multi-preset CRC engine. Message bytes are
// sent with random gaps while the result side stalls at random. Every byte
// that is taken is run through a bit-serial CRC tracker kept in the bench,
// and each emitted CRC is compared with the oldest predicted value. Directed
// cases cover unmarked bytes after reset, single-byte messages, preset
// changes inside a message and unknown presets. Random phases then visit
// every preset with mostly well-formed messages and some loose bytes.
// ----------------------------------------------------------------------------
module multi_preset_crc_engine_tb;
  import mpce_pkg::*;

  typedef struct {
    bit              known;
    int unsigned     width;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init;
    logic [CrcW-1:0] xorout;
    bit              refl;
  } catalog_entry_t;

  localparam logic [PaddrW-1:0] ModeAddr = {RegCrcMode, 2'b00};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  in_data_byte = '0;
  logic              in_first_byte = 1'b0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CrcW-1:0]   out_crc_value;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  logic [CrcW-1:0]  expected_crcs[$];
  logic [CrcW-1:0]  running_crc = '0;
  logic [ModeW-1:0] selected_mode = MODE_4_ITU;
  logic [CrcW-1:0]  wanted_crc;
  int               mismatches = 0;
  int               stall_left = 0;
  bit               no_idle = 1'b0;

  multi_preset_crc_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_first_byte(in_first_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_crc_value(out_crc_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic catalog_entry_t lookup_entry(input logic [ModeW-1:0] mode);
    catalog_entry_t e;
    e = '{1'b1, 16, 32'h0, 32'h0, 32'h0, 1'b1};
    case (mode)
      MODE_4_ITU:          e = '{1'b1, 4,  32'h0C,       32'h00,       32'h00,       1'b1};
      MODE_5_EPC:          e = '{1'b1, 5,  32'h09,       32'h09,       32'h00,       1'b0};
      MODE_5_ITU:          e = '{1'b1, 5,  32'h15,       32'h00,       32'h00,       1'b1};
      MODE_5_USB:          e = '{1'b1, 5,  32'h14,       32'h1F,       32'h1F,       1'b1};
      MODE_6_ITU:          e = '{1'b1, 6,  32'h30,       32'h00,       32'h00,       1'b1};
      MODE_7_MMC:          e = '{1'b1, 7,  32'h09,       32'h00,       32'h00,       1'b0};
      MODE_8:              e = '{1'b1, 8,  32'h07,       32'h00,       32'h00,       1'b0};
      MODE_8_ITU:          e = '{1'b1, 8,  32'h07,       32'h00,       32'h55,       1'b0};
      MODE_8_ROHC:         e = '{1'b1, 8,  32'hE0,       32'hFF,       32'h00,       1'b1};
      MODE_8_MAXIM:        e = '{1'b1, 8,  32'h8C,       32'h00,       32'h00,       1'b1};
      MODE_16_IBM:         e = '{1'b1, 16, 32'hA001,     32'h0000,     32'h0000,     1'b1};
      MODE_16_MAXIM:       e = '{1'b1, 16, 32'hA001,     32'h0000,     32'hFFFF,     1'b1};
      MODE_16_USB:         e = '{1'b1, 16, 32'hA001,     32'hFFFF,     32'hFFFF,     1'b1};
      MODE_16_MODBUS:      e = '{1'b1, 16, 32'hA001,     32'hFFFF,     32'h0000,     1'b1};
      MODE_16_CCITT:       e = '{1'b1, 16, 32'h8408,     32'h0000,     32'h0000,     1'b1};
      MODE_16_CCITT_FALSE: e = '{1'b1, 16, 32'h1021,     32'hFFFF,     32'h0000,     1'b0};
      MODE_16_X25:         e = '{1'b1, 16, 32'h8408,     32'hFFFF,     32'hFFFF,     1'b1};
      MODE_16_XMODEM:      e = '{1'b1, 16, 32'h1021,     32'h0000,     32'h0000,     1'b0};
      MODE_16_DNP:         e = '{1'b1, 16, 32'hA6BC,     32'h0000,     32'hFFFF,     1'b1};
      MODE_32:             e = '{1'b1, 32, 32'hEDB88320, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1};
      MODE_32_MPEG2:       e = '{1'b1, 32, 32'h04C11DB7, 32'hFFFFFFFF, 32'h00000000, 1'b0};
      default:             e.known = 1'b0;
    endcase
    return e;
  endfunction

  function automatic logic [CrcW-1:0] low_bits(input int unsigned w);
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    return m[CrcW-1:0];
  endfunction

  // Normal-form presets narrower than a byte are worked left-aligned in 8 bits.
  function automatic logic [CrcW-1:0] fold_byte_into_crc(input catalog_entry_t e,
                                                         input logic [CrcW-1:0] crc,
                                                         input logic [ByteW-1:0] b);
    logic [CrcW-1:0] msk;
    logic [CrcW-1:0] amsk;
    logic [CrcW-1:0] apoly;
    logic [CrcW-1:0] r;
    int unsigned     s;
    int unsigned     aw;
    bit              hi;
    msk = low_bits(e.width);
    if (e.refl) begin
      r = (crc & msk) ^ CrcW'(b);
      for (int i = 0; i < ByteW; i++) begin
        r = r[0] ? ((r >> 1) ^ e.poly) : (r >> 1);
      end
      return r & msk;
    end else begin
      s = (e.width < ByteW) ? ByteW - e.width : 0;
      aw = e.width + s;
      amsk = low_bits(aw);
      apoly = (e.poly << s) & amsk;
      r = ((crc & msk) << s) ^ (CrcW'(b) << (aw - ByteW));
      for (int i = 0; i < ByteW; i++) begin
        hi = r[aw-1];
        r = (r << 1) & amsk;
        if (hi) begin
          r = r ^ apoly;
        end
      end
      return (r >> s) & msk;
    end
  endfunction

  task automatic predict_crc_byte(input logic [ByteW-1:0] b, input bit first, input bit last);
    catalog_entry_t e;
    logic [CrcW-1:0] crc;
    logic [CrcW-1:0] emitted;
    e = lookup_entry(selected_mode);
    emitted = '0;
    if (e.known) begin
      crc = first ? e.init : running_crc;
      crc = fold_byte_into_crc(e, crc, b);
      running_crc = crc;
      emitted = (crc ^ e.xorout) & low_bits(e.width);
    end else begin
      running_crc = '0;
    end
    if (last) begin
      expected_crcs.push_back(emitted);
    end
  endtask

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input bit first, input bit last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first_byte <= first;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    predict_crc_byte(b, first, last);
  endtask

  // Waits out every pending CRC plus the update pipeline, so the engine is idle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_crcs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_mode(input logic [ModeW-1:0] mode);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= ModeAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PdataW'(mode)) begin
      $display("%0t: crc_mode readback mismatch, expected %h, actual %h",
               $time, PdataW'(mode), prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_mode(input logic [ModeW-1:0] mode);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ModeAddr;
    pwdata <= PdataW'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    selected_mode = mode;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    read_mode(mode);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_crcs.size() == 0) begin
          $display("%0t: unexpected CRC transfer, expected none, actual %h",
                   $time, out_crc_value);
          mismatches++;
        end else begin
          wanted_crc = expected_crcs.pop_front();
          if (out_crc_value !== wanted_crc) begin
            $display("%0t: crc_value mismatch, expected %h, actual %h",
                     $time, wanted_crc, out_crc_value);
            mismatches++;
          end
        end
        stall_left = draw_wait();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic test_unmarked_after_reset();
    read_mode(MODE_4_ITU);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_single_byte_messages();
    crc_mode_t modes[3];
    modes = '{MODE_5_EPC, MODE_7_MMC, MODE_32_MPEG2};
    foreach (modes[i]) begin
      drain_pipeline();
      write_mode(modes[i]);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
    end
  endtask

  task automatic test_mode_change_mid_message();
    drain_pipeline();
    write_mode(MODE_16_CCITT_FALSE);
    send_byte(8'hA5, 1'b1, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b0);
    drain_pipeline();
    write_mode(MODE_5_USB);
    send_byte(8'h81, 1'b0, 1'b1);
    drain_pipeline();
    write_mode(MODE_4_ITU);
    send_byte(8'h5A, 1'b1, 1'b0);
    drain_pipeline();
    write_mode(MODE_32);
    send_byte(8'hC3, 1'b0, 1'b1);
  endtask

  task automatic test_unknown_modes();
    drain_pipeline();
    write_mode(MODE_LAST_UNKNOWN);
    send_byte(8'h7E, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    drain_pipeline();
    write_mode(MODE_FIRST_UNKNOWN);
    send_byte(8'hFF, 1'b1, 1'b1);
    drain_pipeline();
    write_mode(MODE_8_ROHC);
    send_byte(8'h12, 1'b0, 1'b1);
  endtask

  task automatic test_random_messages();
    logic [ModeW-1:0] mode;
    int               sent;
    int               len;
    bit               carry;
    carry = 1'b0;
    for (int ph = 0; ph < 28; ph++) begin
      if (ph < 21) begin
        mode = ModeW'(ph);
      end else if (ph == 21) begin
        mode = MODE_FIRST_UNKNOWN;
      end else if (ph == 22) begin
        mode = MODE_LAST_UNKNOWN;
      end else begin
        mode = ModeW'($urandom_range(0, 31));
      end
      drain_pipeline();
      write_mode(mode);
      no_idle = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 16) begin
        if ($urandom_range(0, 6) == 0) begin
          send_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            send_byte(ByteW'($urandom_range(0, 255)), (k == 0) && !carry, k == len - 1);
          end
          carry = 1'b0;
          sent += len;
        end
      end
      // An open message here is finished under the next preset.
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send_byte(ByteW'($urandom_range(0, 255)), k == 0, 1'b0);
        end
        carry = 1'b1;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unmarked_after_reset();
    test_single_byte_messages();
    test_mode_change_mid_message();
    test_unknown_modes();
    test_random_messages();
    drain_pipeline();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/mpce_pkg.sv
src/multi_preset_crc_engine.sv
src/mpce_checker.sv
verif/multi_preset_crc_engine_tb.sv
